// File: rtl/pwm_dwp_pkg.sv
// Package for the PWM divider and wrap planner.
// Holds the sequencer state type, register codes and fixed constants; no dependencies.
package pwm_dwp_pkg;

  localparam int DIV_W = 28;
  localparam int DVS_W = 24;
  localparam int CNT_W = 5;

  localparam logic [27:0] CLOCK_RESET  = 28'd125000000;
  localparam logic [15:0] MAXF_RESET   = 16'd16000;
  localparam logic [15:0] WRAP_MAX     = 16'hFFFF;
  localparam logic [7:0]  DIV_LAST_TRY = 8'd254;
  localparam logic [7:0]  DIV_FALLBACK = 8'd255;
  localparam logic [23:0] DUTY_FULL    = 24'd255;
  localparam logic [27:0] QUO_FIT_MAX  = 28'd65536;

  typedef enum logic [0:0] {
    REG_CLOCK = 1'b0,
    REG_MAXF  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_TRY,
    S_LMUL,
    S_LDIV,
    S_DONE
  } state_t;

endpackage

// File: rtl/pwm_divider_wrap_planner_top.sv
// PWM divider and wrap planner: per-pin cache, divider search and compare level.
// A cache hit skips the divider search; a full search tries up to 254 dividers.
// One item at a time; the search and the compare level share the 28-step
// restoring divider. Sync active-low reset loads register defaults and
// clears pin flags. Depends on pwm_dwp_pkg.
module pwm_divider_wrap_planner_top #(
  parameter int NUM_PINS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_pin_number,
  input  logic [31:0] in_requested_freq,
  input  logic [7:0]  in_duty_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slice_index,
  output logic        out_channel_index,
  output logic        out_first_use,
  output logic        out_reconfigured,
  output logic [7:0]  out_divider_int,
  output logic [15:0] out_wrap_value,
  output logic [16:0] out_compare_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PIN_AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int DIV_W  = pwm_dwp_pkg::DIV_W;
  localparam int DVS_W  = pwm_dwp_pkg::DVS_W;

  pwm_dwp_pkg::state_t state_r, state_nxt;

  logic [27:0]         clock_hz_r;
  logic [15:0]         max_freq_r;
  logic [NUM_PINS-1:0] pin_active_r;
  logic [31:0]         mem_r [NUM_PINS];
  logic [31:0]         rd_data_r;

  logic [4:0]          pin_r;
  logic [PIN_AW-1:0]   idx_r;
  logic                in_range_r;
  logic [15:0]         freq_r;
  logic [7:0]          duty_r;
  logic                first_r;
  logic                recfg_r;
  logic [7:0]          div_r;
  logic [7:0]          d_r;
  logic [15:0]         wrap_r;

  logic [DVS_W:0]               rem_r;
  logic [DIV_W-1:0]             quo_r;
  logic [DVS_W-1:0]             dvs_r;
  logic [pwm_dwp_pkg::CNT_W-1:0] cnt_r;

  logic        out_valid_r;
  logic [2:0]  out_slice_r;
  logic        out_chan_r;
  logic        out_first_r;
  logic        out_recfg_r;
  logic [7:0]  out_div_r;
  logic [15:0] out_wrap_r;
  logic [16:0] out_level_r;

  logic              in_fire;
  logic              cfg_wr;
  logic [15:0]       maxf_eff;
  logic [15:0]       freq_clamp;
  logic [6:0]        pin_ext;
  logic [PIN_AW-1:0] in_idx;
  logic              in_range;
  logic              active;
  logic [15:0]       cached_freq;
  logic [15:0]       cached_wrap;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    dvs_ext;
  logic              rem_ge;
  logic [DVS_W:0]    rem_diff;
  logic              fit;
  logic              last_try;
  logic [15:0]       q_m1;
  logic              mem_we;
  logic [15:0]       wr_wrap;
  logic [16:0]       wrap_plus;
  logic [24:0]       lvl_prod;
  logic              out_free;

  assign in_ready  = (state_r == pwm_dwp_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign out_free  = !out_valid_r || out_ready;

  assign maxf_eff   = (max_freq_r == 16'd0) ? 16'd1 : max_freq_r;
  assign freq_clamp = (in_requested_freq == 32'd0) ? 16'd1 :
                      (in_requested_freq > {16'd0, maxf_eff}) ? maxf_eff :
                      in_requested_freq[15:0];
  assign pin_ext    = {2'b00, in_pin_number};
  assign in_idx     = pin_ext[PIN_AW-1:0];
  assign in_range   = (pin_ext < 7'(NUM_PINS));

  assign active      = pin_active_r[idx_r];
  assign cached_freq = active ? rd_data_r[31:16] : 16'd0;
  assign cached_wrap = active ? rd_data_r[15:0] : 16'd0;

  assign rem_sh   = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
  assign dvs_ext  = {1'b0, dvs_r};
  assign rem_ge   = (rem_sh >= dvs_ext);
  assign rem_diff = rem_sh - dvs_ext;

  assign fit      = (quo_r != '0) && (quo_r <= pwm_dwp_pkg::QUO_FIT_MAX);
  assign last_try = (d_r == pwm_dwp_pkg::DIV_LAST_TRY);
  assign q_m1     = 16'(quo_r - 28'd1);
  assign mem_we   = (state_r == pwm_dwp_pkg::S_TRY) && (fit || last_try);
  assign wr_wrap  = fit ? q_m1 : pwm_dwp_pkg::WRAP_MAX;

  assign wrap_plus = {1'b0, wrap_r} + 17'd1;
  assign lvl_prod  = 25'(duty_r) * 25'(wrap_plus);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= pwm_dwp_pkg::CLOCK_RESET;
      max_freq_r <= pwm_dwp_pkg::MAXF_RESET;
    end else if (cfg_wr) begin
      unique case (pwm_dwp_pkg::reg_idx_t'(paddr[2]))
        pwm_dwp_pkg::REG_CLOCK: clock_hz_r <= pwdata[27:0];
        pwm_dwp_pkg::REG_MAXF:  max_freq_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pwm_dwp_pkg::reg_idx_t'(paddr[2]))
      pwm_dwp_pkg::REG_CLOCK: prdata = {4'd0, clock_hz_r};
      pwm_dwp_pkg::REG_MAXF:  prdata = {16'd0, max_freq_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[idx_r] <= {freq_r, wr_wrap};
    end
    if (in_fire) begin
      rd_data_r <= mem_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwm_dwp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwm_dwp_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_range ? pwm_dwp_pkg::S_LOOK : pwm_dwp_pkg::S_DONE;
        end
      end
      pwm_dwp_pkg::S_LOOK: begin
        state_nxt = (freq_r != cached_freq) ? pwm_dwp_pkg::S_DIV : pwm_dwp_pkg::S_LMUL;
      end
      pwm_dwp_pkg::S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = pwm_dwp_pkg::S_TRY;
        end
      end
      pwm_dwp_pkg::S_TRY: begin
        state_nxt = (fit || last_try) ? pwm_dwp_pkg::S_LMUL : pwm_dwp_pkg::S_DIV;
      end
      pwm_dwp_pkg::S_LMUL: state_nxt = pwm_dwp_pkg::S_LDIV;
      pwm_dwp_pkg::S_LDIV: begin
        if (cnt_r == '0) begin
          state_nxt = pwm_dwp_pkg::S_DONE;
        end
      end
      pwm_dwp_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = pwm_dwp_pkg::S_IDLE;
        end
      end
      default: state_nxt = pwm_dwp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_active_r <= '0;
    end else if (state_r == pwm_dwp_pkg::S_LOOK) begin
      pin_active_r[idx_r] <= 1'b1;
    end
  end

  // datapath and shared divider
  always_ff @(posedge clk) begin
    unique case (state_r)
      pwm_dwp_pkg::S_IDLE: begin
        if (in_fire) begin
          pin_r      <= in_pin_number;
          idx_r      <= in_idx;
          in_range_r <= in_range;
          freq_r     <= freq_clamp;
          duty_r     <= in_duty_value;
          first_r    <= 1'b0;
          recfg_r    <= 1'b0;
          div_r      <= 8'd0;
          wrap_r     <= 16'd0;
        end
      end
      pwm_dwp_pkg::S_LOOK: begin
        first_r <= !active;
        wrap_r  <= cached_wrap;
        d_r     <= 8'd1;
        dvs_r   <= {8'd0, freq_r};
        quo_r   <= clock_hz_r;
        rem_r   <= '0;
        cnt_r   <= pwm_dwp_pkg::CNT_W'(pwm_dwp_pkg::DIV_W - 1);
      end
      pwm_dwp_pkg::S_DIV, pwm_dwp_pkg::S_LDIV: begin
        rem_r <= rem_ge ? rem_diff : rem_sh;
        quo_r <= {quo_r[DIV_W-2:0], rem_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      pwm_dwp_pkg::S_TRY: begin
        if (fit || last_try) begin
          recfg_r <= 1'b1;
          div_r   <= fit ? d_r : pwm_dwp_pkg::DIV_FALLBACK;
          wrap_r  <= wr_wrap;
        end else begin
          d_r   <= d_r + 8'd1;
          dvs_r <= dvs_r + {8'd0, freq_r};
          quo_r <= clock_hz_r;
          rem_r <= '0;
          cnt_r <= pwm_dwp_pkg::CNT_W'(pwm_dwp_pkg::DIV_W - 1);
        end
      end
      pwm_dwp_pkg::S_LMUL: begin
        dvs_r <= pwm_dwp_pkg::DUTY_FULL;
        quo_r <= DIV_W'(lvl_prod);
        rem_r <= '0;
        cnt_r <= pwm_dwp_pkg::CNT_W'(pwm_dwp_pkg::DIV_W - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pwm_dwp_pkg::S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pwm_dwp_pkg::S_DONE && out_free) begin
      out_slice_r <= pin_r[3:1];
      out_chan_r  <= pin_r[0];
      out_first_r <= first_r;
      out_recfg_r <= recfg_r;
      out_div_r   <= div_r;
      out_wrap_r  <= wrap_r;
      out_level_r <= in_range_r ? quo_r[16:0] : 17'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slice_index   = out_slice_r;
  assign out_channel_index = out_chan_r;
  assign out_first_use     = out_first_r;
  assign out_reconfigured  = out_recfg_r;
  assign out_divider_int   = out_div_r;
  assign out_wrap_value    = out_wrap_r;
  assign out_compare_level = out_level_r;

  a_div_only_on_recfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reconfigured || out_divider_int == 8'd0))
    else $error("divider set without reconfiguration");

  a_recfg_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reconfigured) |-> (out_divider_int != 8'd0))
    else $error("reconfigured item with zero divider");

  a_first_implies_recfg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_use) |-> out_reconfigured)
    else $error("first use without reconfiguration");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_compare_level <= ({1'b0, out_wrap_value} + 17'd1)))
    else $error("compare level above wrap plus one");

  a_try_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pwm_dwp_pkg::S_TRY) |-> (d_r != 8'd0 && d_r <= pwm_dwp_pkg::DIV_LAST_TRY))
    else $error("divider trial out of range");

endmodule
